// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition");

`endif

// ===== rtl/cabs_pkg.sv =====
// shared types and constants for the complex magnitude argmax block
package cabs_pkg;

    localparam int FLOAT_W        = 32;
    localparam int EXP_W          = 8;
    localparam int FRAC_W         = 23;
    localparam int INDEX_W        = 32;
    localparam int COUNT_BITS_DEF = 32;

    localparam logic [EXP_W-1:0]   EXP_MAX = '1;
    localparam logic [FLOAT_W-2:0] POS_INF = {EXP_MAX, {FRAC_W{1'b0}}};

    typedef struct packed {
        logic [FLOAT_W-1:0] real_part;
        logic [FLOAT_W-1:0] imag_part;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0] max_index;
        logic               hit_nan;
    } t_out_item;

    typedef struct packed {
        logic [FLOAT_W-2:0] mag;
        logic               is_nan;
        logic               last;
    } t_mag_item;

endpackage

// ===== rtl/cabs_fadd.sv =====
// |re|+|im| as a round-to-nearest-even binary32 add of two non-negative values
module cabs_fadd (
    input  logic [cabs_pkg::FLOAT_W-1:0] i_real,
    input  logic [cabs_pkg::FLOAT_W-1:0] i_imag,
    output logic [cabs_pkg::FLOAT_W-2:0] o_mag,
    output logic                         o_nan
);
    localparam int EW = cabs_pkg::EXP_W;
    localparam int FW = cabs_pkg::FRAC_W;
    localparam int SW = FW + 1;
    localparam int AW = SW + 3;
    localparam int WW = SW + AW;

    logic [EW+FW-1:0] a, b, big, sml;
    logic             a_inf, b_inf, a_nan, b_nan;
    logic [EW-1:0]    e_big, e_sml, d;
    logic [4:0]       d_cap;
    logic [SW-1:0]    s_big, s_sml;
    logic [WW-1:0]    wide;
    logic [AW-1:0]    aligned;
    logic [AW:0]      sum;
    logic [AW-1:0]    m;
    logic [EW:0]      e_norm;
    logic [EW-1:0]    e_field;
    logic             rnd_up;
    logic [EW+FW-1:0] packed_mag;

    always_comb begin
        a     = i_real[EW+FW-1:0];
        b     = i_imag[EW+FW-1:0];
        a_inf = (a[EW+FW-1:FW] == cabs_pkg::EXP_MAX) && (a[FW-1:0] == '0);
        b_inf = (b[EW+FW-1:FW] == cabs_pkg::EXP_MAX) && (b[FW-1:0] == '0);
        a_nan = (a[EW+FW-1:FW] == cabs_pkg::EXP_MAX) && (a[FW-1:0] != '0);
        b_nan = (b[EW+FW-1:FW] == cabs_pkg::EXP_MAX) && (b[FW-1:0] != '0);

        if (a >= b) begin
            big = a;
            sml = b;
        end else begin
            big = b;
            sml = a;
        end
        e_big = (big[EW+FW-1:FW] == '0) ? EW'(1) : big[EW+FW-1:FW];
        e_sml = (sml[EW+FW-1:FW] == '0) ? EW'(1) : sml[EW+FW-1:FW];
        s_big = {big[EW+FW-1:FW] != '0, big[FW-1:0]};
        s_sml = {sml[EW+FW-1:FW] != '0, sml[FW-1:0]};
        d     = e_big - e_sml;
        d_cap = (d > EW'(AW)) ? 5'(AW) : d[4:0];

        wide    = {s_sml, {AW{1'b0}}} >> d_cap;
        aligned = {wide[WW-1:SW+1], |wide[SW:0]};
        sum     = {1'b0, s_big, 3'b000} + {1'b0, aligned};

        if (sum[AW]) begin
            m      = {sum[AW:2], sum[1] | sum[0]};
            e_norm = {1'b0, e_big} + (EW+1)'(1);
        end else begin
            m      = sum[AW-1:0];
            e_norm = {1'b0, e_big};
        end
        e_field = m[AW-1] ? e_norm[EW-1:0] : '0;
        rnd_up  = m[2] & (m[1] | m[0] | m[3]);
        packed_mag = {e_field, m[AW-2:3]} + (EW+FW)'(rnd_up);

        o_nan = a_nan | b_nan;
        if (a_inf || b_inf || (e_norm >= {1'b0, cabs_pkg::EXP_MAX})) begin
            o_mag = cabs_pkg::POS_INF;
        end else begin
            o_mag = packed_mag;
        end
    end

endmodule

// ===== rtl/cabs_track.sv =====
// running maximum, position counter and result register
module cabs_track #(
    parameter int COUNT_BITS = cabs_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cabs_pkg::t_mag_item i_mag,
    output logic                o_take,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cabs_pkg::t_out_item o_out_item
);
    localparam int IW = cabs_pkg::INDEX_W;
    localparam int XW = (COUNT_BITS > IW) ? COUNT_BITS : IW;

    logic [cabs_pkg::FLOAT_W-2:0] r_best, n_best;
    logic [COUNT_BITS-1:0]        r_pos, n_pos, r_count, n_count;
    logic                         r_nan, n_nan;
    logic                         r_out_valid;
    cabs_pkg::t_out_item          r_out_item;
    logic                         out_free;
    logic [XW-1:0]                pos_ext;
    logic [IW-1:0]                index;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_take   = i_valid && (!i_mag.last || out_free);

    always_comb begin
        n_best = r_best;
        n_pos  = r_pos;
        n_nan  = r_nan;
        if (!r_nan) begin
            if (i_mag.is_nan) begin
                n_nan = 1'b1;
                n_pos = r_count;
            end else if ((r_count == '0) || (i_mag.mag > r_best)) begin
                n_best = i_mag.mag;
                n_pos  = r_count;
            end
        end
        n_count = (r_count == '1) ? r_count : r_count + COUNT_BITS'(1);
        pos_ext = XW'(n_pos);
    end

    generate
        if (XW > IW) begin : g_wide
            assign index = (|pos_ext[XW-1:IW]) ? '1 : pos_ext[IW-1:0];
        end else begin : g_narrow
            assign index = pos_ext[IW-1:0];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_nan       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take && i_mag.last) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
            if (o_take) begin
                if (i_mag.last) begin
                    r_best  <= '0;
                    r_pos   <= '0;
                    r_count <= '0;
                    r_nan   <= 1'b0;
                end else begin
                    r_best  <= n_best;
                    r_pos   <= n_pos;
                    r_count <= n_count;
                    r_nan   <= n_nan;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_mag.last) begin
            r_out_item.max_index <= index;
            r_out_item.hit_nan   <= n_nan;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/complex_abs_argmax.sv =====
// top level of the complex magnitude argmax block
// Streams complex binary32 elements, one per transfer, and returns the zero-based index of
// the first element with the largest |re|+|im| (or of the first NaN) on the transfer marked
// last. Three register stages: input, magnitude add, then running compare with the result
// register. One element is taken every cycle unless the pipeline stalls; the only feedback
// is the single compare against the held maximum. A held result stalls only a following
// last element, never the elements before it.
`include "assert_macros.svh"

module complex_abs_argmax #(
    parameter int COUNT_BITS = cabs_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cabs_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cabs_pkg::t_out_item o_out_item
);
    logic                         r_v1, r_v2;
    cabs_pkg::t_in_item           r_s1;
    cabs_pkg::t_mag_item          r_s2, n_s2;
    logic [cabs_pkg::FLOAT_W-2:0] w_mag;
    logic                         w_nan;
    logic                         w_take;
    logic                         s2_load, s1_load;

    assign s2_load    = !r_v2 || w_take;
    assign s1_load    = !r_v1 || s2_load;
    assign o_in_stall = !s1_load;

    cabs_fadd u_fadd (
        .i_real (r_s1.real_part),
        .i_imag (r_s1.imag_part),
        .o_mag  (w_mag),
        .o_nan  (w_nan)
    );

    always_comb begin
        n_s2.mag    = w_mag;
        n_s2.is_nan = w_nan;
        n_s2.last   = r_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_load) begin
                r_v1 <= i_in_valid;
            end
            if (s2_load) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) begin
            r_s1 <= i_in_item;
        end
        if (s2_load && r_v1) begin
            r_s2 <= n_s2;
        end
    end

    cabs_track #(
        .COUNT_BITS (COUNT_BITS)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_v2),
        .i_mag       (r_s2),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // a result only follows a last element taken by the compare stage
    `ASSERT_PROP(a_result_after_last, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(w_take && r_s2.last))
    // a waiting magnitude is never dropped
    `ASSERT_PROP(a_s2_held, i_clk, i_rst_n, (r_v2 && !w_take) |=> (r_v2 && $stable(r_s2)))
    // a waiting input stage item is never dropped
    `ASSERT_PROP(a_s1_held, i_clk, i_rst_n, (r_v1 && !s1_load) |=> (r_v1 && $stable(r_s1)))
    // a last element never enters compare while a result is held and stalled
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, w_take && r_s2.last && o_out_valid && i_out_stall)

endmodule

// ===== test/complex_abs_argmax_tb.sv =====
// testbench for the complex magnitude argmax block: directed and random vectors, scoreboard check
module complex_abs_argmax_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    cabs_pkg::t_in_item  i_in_item;
    logic                o_out_valid;
    logic                i_out_stall;
    cabs_pkg::t_out_item o_out_item;

    complex_abs_argmax DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    // running state of the argmax predictor
    logic [cabs_pkg::FLOAT_W-2:0] peak_mag;
    logic [cabs_pkg::INDEX_W-1:0] peak_pos;
    logic [cabs_pkg::INDEX_W-1:0] elem_pos;
    logic                         nan_found;

    cabs_pkg::t_out_item expected_results[$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          out_count   = 0;
    int          drawn_idx   = -1;
    int          stall_left  = 0;
    bit          quiet;
    logic [31:0] prev_re, prev_im;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // |re| + |im| of two non-negative binary32 values, round to nearest even
    function automatic logic [cabs_pkg::FLOAT_W-2:0] mag_sum(logic [cabs_pkg::FLOAT_W-2:0] a,
                                                             logic [cabs_pkg::FLOAT_W-2:0] b);
        logic [cabs_pkg::FLOAT_W-2:0] t;
        int          ea, eb, d, ef;
        logic [26:0] ma, mb, sb;
        logic [27:0] s;
        logic [24:0] r;
        if ((a[30:23] == cabs_pkg::EXP_MAX && a[22:0] != 0) ||
            (b[30:23] == cabs_pkg::EXP_MAX && b[22:0] != 0))
            return {cabs_pkg::EXP_MAX, 23'h400000};
        if (a[30:23] == cabs_pkg::EXP_MAX || b[30:23] == cabs_pkg::EXP_MAX)
            return cabs_pkg::POS_INF;
        if (b[30:23] > a[30:23]) begin
            t = a;
            a = b;
            b = t;
        end
        ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
        ma = {a[30:23] != 0, a[22:0], 3'b000};
        mb = {b[30:23] != 0, b[22:0], 3'b000};
        d = ea - eb;
        if (d >= 27)
            sb = {26'd0, mb != 0};
        else
            sb = (mb >> d) | {26'd0, (mb & ((27'd1 << d) - 27'd1)) != 0};
        s = {1'b0, ma} + {1'b0, sb};
        if (s[27]) begin
            s = (s >> 1) | {27'd0, s[0]};
            ea++;
        end
        r = {1'b0, s[26:3]};
        if (s[2] && (s[1] || s[0] || r[0]))
            r = r + 25'd1;
        if (r[24]) begin
            r = r >> 1;
            ea++;
        end
        ef = r[23] ? ea : 0;
        if (ef >= 255)
            return cabs_pkg::POS_INF;
        return {ef[7:0], r[22:0]};
    endfunction

    task automatic track_element(cabs_pkg::t_in_item it);
        logic [cabs_pkg::FLOAT_W-2:0] m;
        cabs_pkg::t_out_item          res;
        if (!nan_found) begin
            m = mag_sum(it.real_part[30:0], it.imag_part[30:0]);
            if (m[30:23] == cabs_pkg::EXP_MAX && m[22:0] != 0) begin
                nan_found = 1'b1;
                peak_pos  = elem_pos;
            end else if (elem_pos == 0 || m > peak_mag) begin
                peak_mag = m;
                peak_pos = elem_pos;
            end
        end
        if (elem_pos != '1)
            elem_pos++;
        if (it.last) begin
            res.max_index = peak_pos;
            res.hit_nan   = nan_found;
            expected_results.push_back(res);
            peak_mag  = '0;
            peak_pos  = '0;
            elem_pos  = '0;
            nan_found = 1'b0;
        end
    endtask

    task automatic send_element(logic [31:0] re, logic [31:0] im, logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid          = 1'b1;
        i_in_item.real_part = re;
        i_in_item.imag_part = im;
        i_in_item.last      = last;
        do @(posedge i_clk); while (o_in_stall);
        track_element(i_in_item);
        prev_re = re;
        prev_im = im;
    endtask

    // downstream stall: a fresh wait drawn for every result, zero in quiet mode
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall = 1'b0;
            stall_left  = 0;
        end else if (o_out_valid) begin
            if (drawn_idx != out_count) begin
                drawn_idx  = out_count;
                stall_left = quiet ? 0 : $urandom_range(0, 17);
            end
            if (stall_left > 0) begin
                i_out_stall = 1'b1;
                stall_left--;
            end else begin
                i_out_stall = 1'b0;
            end
        end else begin
            i_out_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cabs_pkg::t_out_item want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            out_count++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: index %0d nan %0b",
                             o_out_item.max_index, o_out_item.hit_nan);
            end else begin
                want = expected_results.pop_front();
                if (o_out_item !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected index %0d nan %0b, got index %0d nan %0b",
                                 want.max_index, want.hit_nan,
                                 o_out_item.max_index, o_out_item.hit_nan);
                end
            end
        end
    end

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 11))
            0: v[30:0] = '0;
            1: v[30:23] = '0;
            2: v[30:0] = cabs_pkg::POS_INF;
            3: v[30:23] = cabs_pkg::EXP_MAX;
            4: v[30:23] = 8'hFE;
            5: v[30:23] = $urandom_range(120, 135);
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        quiet = 1'b1;
        send_element(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_element(32'hFFC0_0000, 32'h3F80_0000, 1'b1);
        send_element(32'h3F80_0000, 32'h0000_0000, 1'b0);
        send_element(32'hBF80_0000, 32'h8000_0000, 1'b0);
        send_element(32'h0000_0000, 32'h3F80_0000, 1'b0);
        send_element(32'h7F80_0000, 32'h0000_0000, 1'b0);
        send_element(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1);
        quiet = 1'b0;
        send_element(32'h007F_FFFF, 32'h807F_FFFF, 1'b0);
        send_element(32'h0000_0001, 32'h0000_0001, 1'b0);
        send_element(32'h7F80_0001, 32'h4000_0000, 1'b0);
        send_element(32'h7F80_0000, 32'h7F80_0000, 1'b1);
        send_element(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_element(32'h7F7F_FFFF, 32'h3380_0000, 1'b0);
        send_element(32'h7F80_0000, 32'hFF80_0000, 1'b0);
        send_element(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_element(32'h3F80_0000, 32'h3380_0001, 1'b0);
        send_element(32'h3380_0001, 32'h3F80_0000, 1'b1);
    endtask

    task automatic test_random();
        int n, len, k;
        bit noise;
        n = 0;
        while (n < 600) begin
            if ($urandom_range(0, 9) == 0)
                quiet = !quiet;
            len   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
            noise = $urandom_range(0, 5) == 0;
            for (k = 0; k < len; k++) begin
                if (k > 0 && $urandom_range(0, 4) == 0)
                    send_element($urandom_range(0, 1) ? prev_re : prev_im ^ 32'h8000_0000,
                                 $urandom_range(0, 1) ? prev_im : prev_re, k == len - 1);
                else if (noise)
                    send_element($urandom, $urandom, k == len - 1);
                else
                    send_element(pick_value(), pick_value() & 32'hBFFF_FFFF | (32'h1 << 30 &
                                 {32{$urandom_range(0, 3) == 0}}), k == len - 1);
                n++;
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        quiet       = 1'b0;
        peak_mag    = '0;
        peak_pos    = '0;
        elem_pos    = '0;
        nan_found   = 1'b0;
        prev_re     = '0;
        prev_im     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
